// ===== hw/rtl/bhti_pkg.sv =====
// Shared types and constants of the bucketed hash table insert unit.
package bhti_pkg;

	localparam int KEY_W  = 64;
	localparam int QUAL_W = 18;

	localparam logic [1:0] BOUND_EXACT = 2'd3;

	localparam logic [1:0] CFG_GENERATION = 2'd0;
	localparam logic [1:0] CFG_PENALTY    = 2'd1;
	localparam logic [1:0] CFG_BONUS      = 2'd2;

	localparam logic [7:0] PENALTY_RESET = 8'd8;
	localparam logic [7:0] BONUS_RESET   = 8'd8;

	typedef enum logic [1:0] {
		OUT_HIT_UPDATED     = 2'd0,
		OUT_HIT_KEPT        = 2'd1,
		OUT_EMPTY_FILLED    = 2'd2,
		OUT_VICTIM_REPLACED = 2'd3
	} outcome_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INDEX,
		ST_EVAL,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic [63:0]        position_key;
		logic signed [15:0] result_score;
		logic signed [15:0] search_depth;
		logic [15:0]        best_move_code;
		logic [1:0]         bound_kind;
		logic               principal_flag;
	} req_t;

	typedef struct packed {
		outcome_t   outcome;
		logic [1:0] way_used;
	} rsp_t;

	typedef struct packed {
		logic [7:0] generation;
		logic [7:0] penalty;
		logic [7:0] bonus;
	} cfg_t;

	// One way of a bucket; bound in bits 1..0 of bound_flag, principal flag in bit 2.
	typedef struct packed {
		logic [63:0]        key;
		logic signed [15:0] score;
		logic signed [15:0] depth;
		logic [15:0]        move;
		logic [2:0]         bound_flag;
		logic [7:0]         age;
	} entry_t;

	typedef struct packed {
		outcome_t outcome;
		entry_t   entry;
	} dec_t;

endpackage

// ===== hw/rtl/bucketed_hash_table_insert_unit.sv =====
// Top level of the bucketed hash table insert unit.
//
//  channel   direction  handshake              payload
//  request   in         start & !busy          req   (req_t)
//  result    out        done, one cycle        rsp   (rsp_t)
//  config    in         cfg_we                 cfg_index, cfg_wdata
//
// A request passes bucket read, way evaluation and write-back when BUCKET_COUNT
// is a power of two; the result strobe follows in the cycle after the write,
// when the next request may already be taken. Otherwise the serial modulo unit
// first reduces the key, four key bits per cycle.
// After reset the memory is cleared one bucket per cycle, every bucket in turn,
// with busy high; configuration writes are taken throughout.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bucketed_hash_table_insert_unit
	import bhti_pkg::*;
#(
	parameter int BUCKET_COUNT = 1024,
	parameter int WAYS_PER_BUCKET = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	output logic       done,
	output rsp_t       rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	localparam int BW   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int WAYW = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
	localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKET_COUNT - 1);

	state_t  state_q;
	state_t  state_nx;
	cfg_t    cfg_q;
	req_t    req_q;
	logic [BW-1:0] clr_q;
	logic    done_q;
	rsp_t    rsp_q;

	logic    accept;
	logic    idx_done;
	logic [BW-1:0] bucket;
	logic [BW-1:0] bucket_q;
	logic    eval_load;
	logic    commit;

	entry_t [WAYS_PER_BUCKET-1:0] rd_row;
	entry_t [WAYS_PER_BUCKET-1:0] wr_row;
	logic [WAYS_PER_BUCKET-1:0]   wr_mask;
	logic [BW-1:0]                wr_addr;

	dec_t            dec;
	logic [WAYW-1:0] way;

	assign accept = start && !busy;

	bhti_bucket_index #(
		.BUCKET_COUNT(BUCKET_COUNT),
		.BW(BW)
	) u_index (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.key(req.position_key),
		.done(idx_done),
		.bucket(bucket)
	);

	bhti_bucket_mem #(
		.BUCKET_COUNT(BUCKET_COUNT),
		.WAYS(WAYS_PER_BUCKET),
		.BW(BW)
	) u_mem (
		.clk(clk),
		.rd_en(idx_done),
		.rd_addr(bucket),
		.rd_row(rd_row),
		.wr_mask(wr_mask),
		.wr_addr(wr_addr),
		.wr_row(wr_row)
	);

	bhti_way_eval #(
		.WAYS(WAYS_PER_BUCKET),
		.WAYW(WAYW)
	) u_eval (
		.clk(clk),
		.load(eval_load),
		.row(rd_row),
		.req(req_q),
		.cfg(cfg_q),
		.dec(dec),
		.way(way)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_BUCKET) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_nx = idx_done ? ST_EVAL : ST_INDEX;
				end
			end
			ST_INDEX: begin
				if (idx_done) begin
					state_nx = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_nx = ST_COMMIT;
			end
			ST_COMMIT: begin
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = state_q != ST_IDLE;
		eval_load = state_q == ST_EVAL;
		commit    = state_q == ST_COMMIT;
		wr_mask   = '0;
		wr_addr   = bucket_q;
		wr_row    = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_mask = '1;
				wr_addr = clr_q;
			end
			ST_COMMIT: begin
				wr_mask = WAYS_PER_BUCKET'(1) << way;
				for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
					wr_row[w] = dec.entry;
				end
			end
			default: begin
				wr_mask = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			cfg_q   <= '{generation: 8'd0, penalty: PENALTY_RESET, bonus: BONUS_RESET};
		end else begin
			state_q <= state_nx;
			done_q  <= commit;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + BW'(1);
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_GENERATION: cfg_q.generation <= cfg_wdata;
					CFG_PENALTY:    cfg_q.penalty    <= cfg_wdata;
					CFG_BONUS:      cfg_q.bonus      <= cfg_wdata;
					default:        cfg_q            <= cfg_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (idx_done) begin
			bucket_q <= bucket;
		end
		if (commit) begin
			rsp_q.outcome  <= dec.outcome;
			rsp_q.way_used <= 2'(way);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// A result strobe only ever follows a write-back cycle.
	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_COMMIT))
		else $error("result strobe without a preceding write-back");

	// The memory is written only while clearing or committing a request.
	a_no_stray_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_mask != '0) |-> (state_q == ST_CLEAR || state_q == ST_COMMIT))
		else $error("memory write outside clear or write-back");

	// A hit outcome must point at a way that holds the request's key.
	a_hit_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (dec.outcome == OUT_HIT_UPDATED || dec.outcome == OUT_HIT_KEPT))
		|-> (rd_row[way].key == req_q.position_key))
		else $error("hit reported on a way whose key differs");

	// Way evaluation only ever follows a bucket read.
	a_read_before_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> $past(idx_done))
		else $error("way evaluation without a bucket read");

endmodule

// ===== hw/rtl/bhti_bucket_index.sv =====
// Bucket index unit: position key modulo the bucket count.
module bhti_bucket_index
	import bhti_pkg::*;
#(
	parameter int BUCKET_COUNT = 1024,
	parameter int BW = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	output logic             done,
	output logic [BW-1:0]    bucket
);

	localparam bit IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;

	generate
		if (IS_POW2) begin : g_mask
			localparam logic [KEY_W-1:0] MASK = KEY_W'(BUCKET_COUNT - 1);

			assign done   = start;
			assign bucket = BW'(key & MASK);
		end else begin : g_serial
			localparam int RW = BW + 4;
			localparam logic [RW-1:0] DIV = RW'(BUCKET_COUNT);

			logic [KEY_W-1:0] key_q;
			logic [BW-1:0]    rem_q;
			logic [3:0]       cnt_q;
			logic             run_q;
			logic [BW-1:0]    rem_nx;

			// Four key bits enter per cycle, most significant first; the
			// remainder stays below the divisor after four conditional subtracts.
			always_comb begin
				logic [RW-1:0] v;
				v = {rem_q, key_q[KEY_W-1 -: 4]};
				for (int k = 3; k >= 0; k--) begin
					if (v >= (DIV << k)) begin
						v = v - (DIV << k);
					end
				end
				rem_nx = v[BW-1:0];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					run_q <= 1'b0;
					cnt_q <= '0;
				end else if (start) begin
					run_q <= 1'b1;
					cnt_q <= '0;
				end else if (run_q) begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'hF) begin
						run_q <= 1'b0;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_q <= key;
					rem_q <= '0;
				end else if (run_q) begin
					key_q <= key_q << 4;
					rem_q <= rem_nx;
				end
			end

			assign done   = run_q && (cnt_q == 4'hF);
			assign bucket = rem_nx;
		end
	endgenerate

endmodule

// ===== hw/rtl/bhti_bucket_mem.sv =====
// Bucket memory: one row per bucket, whole-row read, per-way write.
module bhti_bucket_mem
	import bhti_pkg::*;
#(
	parameter int BUCKET_COUNT = 1024,
	parameter int WAYS = 4,
	parameter int BW = 10
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [BW-1:0]        rd_addr,
	output entry_t [WAYS-1:0]    rd_row,
	input  logic [WAYS-1:0]      wr_mask,
	input  logic [BW-1:0]        wr_addr,
	input  entry_t [WAYS-1:0]    wr_row
);

	entry_t [WAYS-1:0] row_mem [BUCKET_COUNT];

	always_ff @(posedge clk) begin
		for (int w = 0; w < WAYS; w++) begin
			if (wr_mask[w]) begin
				row_mem[wr_addr][w] <= wr_row[w];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row <= row_mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/bhti_way_eval.sv =====
// Way evaluation: per-way match, empty, quality and refresh, then the way choice.
module bhti_way_eval
	import bhti_pkg::*;
#(
	parameter int WAYS = 4,
	parameter int WAYW = 2
) (
	input  logic              clk,
	input  logic              load,
	input  entry_t [WAYS-1:0] row,
	input  req_t              req,
	input  cfg_t              cfg,
	output dec_t              dec,
	output logic [WAYW-1:0]   way
);

	logic [WAYS-1:0]                match_s2;
	logic [WAYS-1:0]                empty_s2;
	logic [WAYS-1:0]                refresh_s2;
	logic signed [QUAL_W-1:0]       qual_s2 [WAYS];

	logic [WAYS-1:0]                match_c;
	logic [WAYS-1:0]                empty_c;
	logic [WAYS-1:0]                refresh_c;
	logic signed [QUAL_W-1:0]       qual_c [WAYS];

	always_comb begin
		logic [7:0]               gen_gap;
		logic [15:0]              prod;
		logic signed [QUAL_W-1:0] q;
		logic signed [QUAL_W-1:0] new_lvl;
		logic signed [QUAL_W-1:0] old_lvl;
		for (int w = 0; w < WAYS; w++) begin
			match_c[w] = row[w].key == req.position_key;
			empty_c[w] = row[w].key == '0;
			gen_gap    = cfg.generation - row[w].age;
			prod       = gen_gap * cfg.penalty;
			q = QUAL_W'(row[w].depth) - $signed({2'b00, prod});
			if (row[w].bound_flag[1:0] == BOUND_EXACT) begin
				q = q + $signed({10'd0, cfg.bonus});
			end
			qual_c[w] = q;
			new_lvl = QUAL_W'(req.search_depth)
				+ $signed({{(QUAL_W-2){1'b0}}, req.principal_flag, 1'b0});
			old_lvl = QUAL_W'(row[w].depth) - QUAL_W'(4);
			refresh_c[w] = (req.bound_kind == BOUND_EXACT)
				|| (row[w].age != cfg.generation)
				|| (new_lvl > old_lvl);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			match_s2   <= match_c;
			empty_s2   <= empty_c;
			refresh_s2 <= refresh_c;
			for (int w = 0; w < WAYS; w++) begin
				qual_s2[w] <= qual_c[w];
			end
		end
	end

	// The first way that matches or is empty decides; otherwise the lowest
	// quality loses its place, the lowest way winning a tie.
	always_comb begin
		logic                     found;
		logic                     hit;
		logic [WAYW-1:0]          sel;
		logic [WAYW-1:0]          best;
		logic signed [QUAL_W-1:0] best_q;
		entry_t                   old;
		entry_t                   nw;
		found  = 1'b0;
		hit    = 1'b0;
		sel    = '0;
		best   = '0;
		best_q = qual_s2[0];
		for (int w = 0; w < WAYS; w++) begin
			if (!found && (match_s2[w] || empty_s2[w])) begin
				found = 1'b1;
				hit   = match_s2[w];
				sel   = WAYW'(w);
			end
		end
		for (int w = 1; w < WAYS; w++) begin
			if (qual_s2[w] < best_q) begin
				best_q = qual_s2[w];
				best   = WAYW'(w);
			end
		end
		way = found ? sel : best;
		old = row[way];
		if (hit) begin
			nw = old;
			if (req.best_move_code != '0) begin
				nw.move = req.best_move_code;
			end
			if (refresh_s2[way]) begin
				nw.score      = req.result_score;
				nw.depth      = req.search_depth;
				nw.bound_flag = {req.principal_flag, req.bound_kind};
				nw.age        = cfg.generation;
				dec.outcome   = OUT_HIT_UPDATED;
			end else begin
				dec.outcome = OUT_HIT_KEPT;
			end
		end else begin
			nw.key        = req.position_key;
			nw.score      = req.result_score;
			nw.depth      = req.search_depth;
			nw.move       = req.best_move_code;
			nw.bound_flag = {req.principal_flag, req.bound_kind};
			nw.age        = cfg.generation;
			dec.outcome   = found ? OUT_EMPTY_FILLED : OUT_VICTIM_REPLACED;
		end
		dec.entry = nw;
	end

endmodule

// ===== verif/bucketed_hash_table_insert_unit_tb.sv =====
// Self-checking testbench for the bucketed hash table insert unit.
`timescale 1ns / 100ps

module bucketed_hash_table_insert_unit_tb;
	import bhti_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 11;
	localparam int BUCKETS      = 1024;
	localparam int WAYS         = 4;
	localparam int SLOTS        = BUCKETS * WAYS;
	localparam int POOL_SIZE    = 36;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	localparam logic [1:0] CFG_UNUSED  = 2'd3;
	localparam logic [1:0] BOUND_NONE  = 2'd0;
	localparam logic [1:0] BOUND_UPPER = 2'd1;
	localparam logic [1:0] BOUND_LOWER = 2'd2;

	localparam logic [63:0] KEY_A    = {54'h1, 10'd5};
	localparam logic [63:0] KEY_B    = {54'h2, 10'd5};
	localparam logic [63:0] KEY_C    = {54'h3, 10'd5};
	localparam logic [63:0] KEY_D    = {54'h4, 10'd5};
	localparam logic [63:0] KEY_E    = {54'h5, 10'd5};
	localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] KEY_ZERO = 64'd0;

	typedef struct {
		req_t item;
		bit   checked;
		rsp_t want;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	req_t       req;
	logic       done;
	rsp_t       rsp;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_wdata;

	// Shadow of the table and the registers.
	entry_t     table_shadow [SLOTS];
	bit         slot_written [SLOTS];
	logic [7:0] generation_reg;
	logic [7:0] penalty_reg;
	logic [7:0] bonus_reg;

	rsp_t        pending_outcomes [$];
	dir_row_t    dir_rows [$];
	logic [63:0] key_pool [POOL_SIZE];
	logic [63:0] last_key;
	int          hot_buckets [6] = '{0, 1, 5, 512, 1022, 1023};
	int          mismatch_count;
	int          cycle_count;

	bucketed_hash_table_insert_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic flag_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic void store_entry(input int slot, input req_t r);
		table_shadow[slot].key        = r.position_key;
		table_shadow[slot].score      = r.result_score;
		table_shadow[slot].depth      = r.search_depth;
		table_shadow[slot].move       = r.best_move_code;
		table_shadow[slot].bound_flag = {r.principal_flag, r.bound_kind};
		table_shadow[slot].age        = generation_reg;
		slot_written[slot]            = 1'b1;
	endfunction

	// Scans the bucket in way order and updates the shadow table as the unit should.
	function automatic rsp_t predict_insert(input req_t r);
		int         base;
		int         slot;
		int         quality;
		int         best_q;
		int         best_w;
		logic [7:0] gen_gap;
		rsp_t       res;
		base   = int'(r.position_key % BUCKETS) * WAYS;
		best_q = 32'h7FFF_FFFF;
		best_w = 0;
		for (int w = 0; w < WAYS; w++) begin
			slot = base + w;
			if (table_shadow[slot].key == r.position_key) begin
				if (r.best_move_code != 16'd0)
					table_shadow[slot].move = r.best_move_code;
				if (r.bound_kind == BOUND_EXACT || table_shadow[slot].age != generation_reg ||
				    int'(r.search_depth) + 2 * int'(r.principal_flag) >
				    int'($signed(table_shadow[slot].depth)) - 4) begin
					table_shadow[slot].score      = r.result_score;
					table_shadow[slot].depth      = r.search_depth;
					table_shadow[slot].bound_flag = {r.principal_flag, r.bound_kind};
					table_shadow[slot].age        = generation_reg;
					res.outcome = OUT_HIT_UPDATED;
				end else begin
					res.outcome = OUT_HIT_KEPT;
				end
				res.way_used = 2'(w);
				return res;
			end
			if (table_shadow[slot].key == 64'd0) begin
				store_entry(slot, r);
				res.outcome  = OUT_EMPTY_FILLED;
				res.way_used = 2'(w);
				return res;
			end
			gen_gap = generation_reg - table_shadow[slot].age;
			quality = int'($signed(table_shadow[slot].depth)) -
			          int'(gen_gap) * int'(penalty_reg);
			if (table_shadow[slot].bound_flag[1:0] == BOUND_EXACT)
				quality += int'(bonus_reg);
			if (quality < best_q) begin
				best_q = quality;
				best_w = w;
			end
		end
		store_entry(base + best_w, r);
		res.outcome  = OUT_VICTIM_REPLACED;
		res.way_used = 2'(best_w);
		return res;
	endfunction

	// A zero key hits the first empty way of bucket zero, whose payload must have been written.
	function automatic bit zero_key_safe();
		for (int w = 0; w < WAYS; w++) begin
			if (table_shadow[w].key == 64'd0)
				return slot_written[w];
		end
		return 1'b1;
	endfunction

	function automatic req_t random_insert();
		req_t r;
		int   pick;
		pick = $urandom_range(0, 19);
		if (pick < 12)
			r.position_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (pick < 16)
			r.position_key = last_key;
		else if (pick < 19)
			r.position_key = {$urandom, $urandom};
		else
			r.position_key = KEY_ZERO;
		if ($urandom_range(0, 9) < 7)
			r.search_depth = 16'(int'($urandom_range(0, 48)) - 8);
		else
			r.search_depth = 16'($urandom);
		r.result_score   = 16'($urandom);
		r.best_move_code = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
		r.bound_kind     = 2'($urandom_range(0, 3));
		r.principal_flag = 1'($urandom_range(0, 1));
		if (r.position_key == KEY_ZERO && !zero_key_safe())
			r.position_key = key_pool[0];
		return r;
	endfunction

	function automatic void add_row(input logic [63:0] key, input int score, input int depth,
	                                input logic [15:0] move, input logic [1:0] bound,
	                                input bit pv, input bit checked, input outcome_t oc,
	                                input logic [1:0] way);
		dir_row_t row;
		row.item.position_key   = key;
		row.item.result_score   = 16'(score);
		row.item.search_depth   = 16'(depth);
		row.item.best_move_code = move;
		row.item.bound_kind     = bound;
		row.item.principal_flag = pv;
		row.checked             = checked;
		row.want.outcome        = oc;
		row.want.way_used       = way;
		dir_rows.push_back(row);
	endfunction

	// Holds the request until the unit takes it; start stays high on return.
	task automatic send_insert(input req_t item, input bit typed, input rsp_t typed_rsp);
		rsp_t predicted;
		start <= 1'b1;
		req   <= item;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predicted = predict_insert(item);
		last_key  = item.position_key;
		pending_outcomes.push_back(typed ? typed_rsp : predicted);
	endtask

	task automatic idle_gap(input int idle_pct);
		if ($urandom_range(0, 39) == 0) begin
			start <= 1'b0;
			req   <= random_insert();
			do
				@(posedge clk);
			while (pending_outcomes.size() != 0);
		end else if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			req   <= random_insert();
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_outcomes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller lowers it after the last write.
	task automatic reg_write(input logic [1:0] index, input logic [7:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(posedge clk);
		case (index)
			CFG_GENERATION: generation_reg = data;
			CFG_PENALTY:    penalty_reg    = data;
			CFG_BONUS:      bonus_reg      = data;
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [7:0] gen, input logic [7:0] pen,
	                            input logic [7:0] bon);
		reg_write(CFG_GENERATION, gen);
		reg_write(CFG_PENALTY, pen);
		reg_write(CFG_BONUS, bon);
		reg_write(CFG_UNUSED, 8'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic run_random_phase(input int count, input int idle_pct);
		rsp_t unused_rsp;
		unused_rsp = '0;
		for (int i = 0; i < count; i++) begin
			if (i > 0)
				idle_gap(idle_pct);
			send_insert(random_insert(), 1'b0, unused_rsp);
		end
		drain_results();
	endtask

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			if (pending_outcomes.size() == 0) begin
				flag_mismatch($sformatf("result with no request pending: outcome=%0d way=%0d",
				                        rsp.outcome, rsp.way_used));
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp.outcome !== want.outcome)
					flag_mismatch($sformatf("outcome %0d, expected %0d",
					                        rsp.outcome, want.outcome));
				if (rsp.way_used !== want.way_used)
					flag_mismatch($sformatf("way_used %0d, expected %0d",
					                        rsp.way_used, want.way_used));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bucketed_hash_table_insert_unit: mismatch");
			$finish;
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		req            = '0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_GENERATION;
		cfg_wdata      = 8'd0;
		mismatch_count = 0;
		cycle_count    = 0;
		generation_reg = 8'd0;
		penalty_reg    = PENALTY_RESET;
		bonus_reg      = BONUS_RESET;
		for (int s = 0; s < SLOTS; s++) begin
			table_shadow[s] = '0;
			slot_written[s] = 1'b0;
		end
		// Six keys share each hot bucket, so hits and victims both come up often.
		for (int k = 0; k < POOL_SIZE; k++) begin
			key_pool[k]      = {$urandom, $urandom};
			key_pool[k][9:0] = 10'(hot_buckets[k % 6]);
		end
		last_key = key_pool[0];

		// Bucket five: fill, keep and update on hits, then evict the weakest way; then an all-ones key fills bucket 1023.
		add_row(KEY_A, 100, 10, 16'h1234, BOUND_UPPER, 0, 1, OUT_EMPTY_FILLED, 2'd0);
		add_row(KEY_A, -1, 3, 16'h0001, BOUND_LOWER, 0, 1, OUT_HIT_KEPT, 2'd0);
		add_row(KEY_A, 0, 5, 16'h0000, BOUND_UPPER, 1, 1, OUT_HIT_UPDATED, 2'd0);
		add_row(KEY_A, 32767, -32768, 16'hFFFF, BOUND_EXACT, 0, 1, OUT_HIT_UPDATED, 2'd0);
		add_row(KEY_A, -32768, -32768, 16'h0000, BOUND_NONE, 0, 1, OUT_HIT_UPDATED, 2'd0);
		add_row(KEY_B, 32767, 32767, 16'hFFFF, BOUND_EXACT, 1, 1, OUT_EMPTY_FILLED, 2'd1);
		add_row(KEY_C, 0, 0, 16'h0000, BOUND_UPPER, 0, 1, OUT_EMPTY_FILLED, 2'd2);
		add_row(KEY_D, 1, 100, 16'h0002, BOUND_LOWER, 0, 1, OUT_EMPTY_FILLED, 2'd3);
		add_row(KEY_E, -2, 1, 16'h0003, BOUND_NONE, 0, 1, OUT_VICTIM_REPLACED, 2'd0);
		add_row(KEY_ONES, -32768, 32767, 16'hFFFF, BOUND_EXACT, 1, 1, OUT_EMPTY_FILLED, 2'd0);
		// Bucket zero: fill it, then a zero key evicts a way and hits it afterwards.
		add_row({54'hA, 10'd0}, 5, 1, 16'h0010, BOUND_UPPER, 0, 1, OUT_EMPTY_FILLED, 2'd0);
		add_row({54'hB, 10'd0}, 6, 2, 16'h0011, BOUND_LOWER, 1, 1, OUT_EMPTY_FILLED, 2'd1);
		add_row({54'hC, 10'd0}, 7, 3, 16'h0012, BOUND_NONE, 0, 1, OUT_EMPTY_FILLED, 2'd2);
		add_row({54'hD, 10'd0}, 8, 4, 16'h0013, BOUND_UPPER, 0, 1, OUT_EMPTY_FILLED, 2'd3);
		add_row(KEY_ZERO, 9, 0, 16'h0020, BOUND_LOWER, 0, 1, OUT_VICTIM_REPLACED, 2'd0);
		add_row(KEY_ZERO, 10, -5, 16'h0000, BOUND_UPPER, 0, 1, OUT_HIT_KEPT, 2'd0);
		add_row(KEY_ZERO, 11, -5, 16'h0021, BOUND_EXACT, 0, 1, OUT_HIT_UPDATED, 2'd0);
		add_row({54'h55, 10'd0}, 12, 7, 16'h0022, BOUND_LOWER, 0, 1, OUT_EMPTY_FILLED, 2'd0);
		// Depth margin with and without the principal variation bonus.
		add_row(KEY_B, -1, 32767, 16'h0000, BOUND_UPPER, 1, 1, OUT_HIT_UPDATED, 2'd1);
		add_row(KEY_C, 13, -3, 16'h0030, BOUND_LOWER, 0, 1, OUT_HIT_UPDATED, 2'd2);
		add_row(KEY_C, 14, -9, 16'h0031, BOUND_LOWER, 1, 1, OUT_HIT_KEPT, 2'd2);
		add_row(KEY_A, 15, 20, 16'h0040, BOUND_LOWER, 0, 0, OUT_HIT_KEPT, 2'd0);
		add_row(KEY_C, -7, 6, 16'h0041, BOUND_EXACT, 1, 0, OUT_HIT_KEPT, 2'd0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < dir_rows.size(); i++)
			send_insert(dir_rows[i].item, dir_rows[i].checked, dir_rows[i].want);
		drain_results();

		program_regs(8'd1, 8'd8, 8'd8);
		run_random_phase(120, 0);
		program_regs(8'd255, 8'd255, 8'd0);
		run_random_phase(110, 46);
		program_regs(8'd0, 8'd0, 8'd255);
		run_random_phase(110, 13);
		program_regs(8'($urandom), 8'($urandom), 8'($urandom));
		run_random_phase(110, 0);

		if (mismatch_count == 0)
			$display("bucketed_hash_table_insert_unit: match");
		else
			$display("bucketed_hash_table_insert_unit: mismatch");
		$finish;
	end

endmodule
